/* src/upd_pkg.sv */
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared constants, types and character helpers for the decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Characters with a special meaning in the encoded stream.
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;

  // Most decoded bytes that one input beat can produce.
  localparam int unsigned MaxOut = 3;

  // Escape phase of the front end.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_e;

  // A group of decoded bytes produced by one input beat.
  typedef struct packed {
    logic [1:0]             cnt;
    logic                   last;
    logic [MaxOut-1:0][7:0] bytes;
  } upd_grp_t;

  // True for 0-9, A-F and a-f.
  function automatic logic is_hex(input logic [7:0] c);
    logic res;
    res = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return res;
  endfunction

  // Nibble value of a hex digit character; zero for anything else.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

endpackage

/* src/upd_in_if.sv */
// ----------------------------------------------------------------------------
// Encoded byte channel
// Valid/ready channel carrying one encoded byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* src/upd_out_if.sv */
// ----------------------------------------------------------------------------
// Decoded byte channel
// Valid/ready channel carrying one decoded byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* src/upd_front.sv */
// ----------------------------------------------------------------------------
// Decoder front end
// Accepts encoded beats, tracks the escape phase and forms the group of
// decoded bytes that each beat produces.
// ----------------------------------------------------------------------------
module upd_front
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output upd_grp_t  grp_o
);

  upd_phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;

  logic       fire;
  logic [7:0] b;
  logic       last;
  logic       do_fresh;
  logic       direct;
  logic [7:0] direct_val;
  logic [1:0] pre_cnt;
  logic [7:0] pre0, pre1;
  logic       f_emit;
  logic [7:0] f_byte;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign last       = in_i.in_last;

  // Classify the beat against the pending escape.
  always_comb begin
    phase_d    = PH_IDLE;
    held_d     = held_q;
    do_fresh   = 1'b0;
    direct     = 1'b0;
    direct_val = {hex_val(held_q), hex_val(b)};
    pre_cnt    = 2'd0;
    pre0       = ChPct;
    pre1       = held_q;
    f_emit     = 1'b0;
    f_byte     = b;
    case (phase_q)
      PH_PCT: begin
        if (!last && is_hex(b)) begin
          held_d  = b;
          phase_d = PH_DIGIT;
        end else begin
          pre_cnt  = 2'd1;
          do_fresh = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(b)) begin
          direct = 1'b1;
        end else begin
          pre_cnt  = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    // Plain decoding of the beat with no escape pending.
    if (do_fresh) begin
      if (b == ChPlus) begin
        f_emit = 1'b1;
        f_byte = ChSpace;
      end else if (b == ChPct && !last) begin
        phase_d = PH_PCT;
      end else begin
        f_emit = 1'b1;
      end
    end
  end

  // Assemble the output group.
  always_comb begin
    grp_o.last     = last;
    grp_o.bytes[0] = pre0;
    grp_o.bytes[1] = pre1;
    grp_o.bytes[2] = 8'h00;
    grp_o.cnt      = pre_cnt;
    if (direct) begin
      grp_o.bytes[0] = direct_val;
      grp_o.cnt      = 2'd1;
    end else if (f_emit) begin
      grp_o.cnt = pre_cnt + 2'd1;
      case (pre_cnt)
        2'd0:    grp_o.bytes[0] = f_byte;
        2'd1:    grp_o.bytes[1] = f_byte;
        default: grp_o.bytes[2] = f_byte;
      endcase
    end
  end

  assign push_o = fire && (grp_o.cnt != 2'd0);

  // Escape state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
    end else if (fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // A message always closes the escape and always yields a result.
  a_last_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last) |=> (phase_q == PH_IDLE))
    else $error("escape still pending after last beat");

  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last) |-> push_o)
    else $error("last beat produced no decoded byte");

endmodule

/* src/upd_queue.sv */
// ----------------------------------------------------------------------------
// Group queue
// Short first-in first-out queue of decoded byte groups between the front
// end and the back end.
// ----------------------------------------------------------------------------
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upd_grp_t wdata_i,
  input  logic     pop_i,
  output upd_grp_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  upd_grp_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("group queue read while empty");

endmodule

/* src/upd_back.sv */
// ----------------------------------------------------------------------------
// Decoder back end
// Holds one group of decoded bytes in the output register and sends its
// bytes one beat at a time, loading the next group as the last one leaves.
// ----------------------------------------------------------------------------
module upd_back
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  upd_grp_t  grp_i,
  input  logic      empty_i,
  output logic      pop_o,
  upd_out_if.source out_o
);

  upd_grp_t   grp_q;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       final_beat;
  logic       load;

  assign fire       = out_o.valid && out_o.ready;
  assign final_beat = (idx_q == grp_q.cnt - 2'd1);
  assign load       = !valid_q || (fire && final_beat);
  assign pop_o      = load && !empty_i;

  // Output payload from the held group.
  always_comb begin
    case (idx_q)
      2'd0:    out_o.out_byte = grp_q.bytes[0];
      2'd1:    out_o.out_byte = grp_q.bytes[1];
      default: out_o.out_byte = grp_q.bytes[2];
    endcase
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_last = grp_q.last && final_beat;

  // Beat index and group occupancy.
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
      idx_d   = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= grp_i;
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < grp_q.cnt))
    else $error("beat index beyond the held group");

  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (grp_q.cnt != 2'd0))
    else $error("empty group held in output register");

endmodule

/* src/url_percent_decoder.sv */
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of percent-encoded text, one encoded byte per beat.
// ----------------------------------------------------------------------------
// Use: encoded bytes arrive on in_i with in_last on the final byte of a
// message; decoded bytes leave on out_o with out_last on the final decoded
// byte. A '+' decodes to a space, a '%' with two hex digits to one byte, and
// a broken or truncated escape is passed through literally.
// Each input beat yields zero to three output beats. The front end takes one
// beat per cycle while the queue is not full and writes each non-empty group
// into a queue of QueueDepth groups; the back end sends one byte per cycle
// from its output register while the receiver is ready. Bytes pass the queue,
// then the output register. Throughput is one input beat per cycle while
// beats decode to at most one byte; a beat that yields several bytes holds the
// back end while they are sent, and in_i.ready drops only when the queue is
// full. When the receiver stalls, the output beat holds and the queue fills,
// after which input is held off. Reset clears the escape phase and empties the
// queue and the output register; no beat is shown until new input arrives.
// ----------------------------------------------------------------------------
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  upd_grp_t grp_wr;
  upd_grp_t grp_rd;

  // Classify beats and form decoded groups.
  upd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .grp_o  (grp_wr)
  );

  // Decouple the two halves.
  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (grp_wr),
    .pop_i   (pop),
    .rdata_o (grp_rd),
    .full_o  (full),
    .empty_o (empty)
  );

  // Serialise groups onto the output channel.
  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .grp_i   (grp_rd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
